FILE: hw/rtl/vna_pkg.sv
// Shared types and constants for the vertex normal accumulator.
package vna_pkg;

    localparam int VERTEX_SLOTS_DEF = 1024;
    localparam int CORNER_W         = 10;
    localparam int DATA_W           = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_TRI    = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Work codes after classification; a read of an out-of-range vertex answers zero.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TRI,
        OP_READ,
        OP_ZERO
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic [CORNER_W-1:0]         ca;
        logic [CORNER_W-1:0]         cb;
        logic [CORNER_W-1:0]         cc;
        logic [2:0][DATA_W-1:0]      pos;
        logic [2:0][DATA_W-1:0]      nrm;
    } item_t;

endpackage

FILE: hw/rtl/vna_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/vna_front.sv
// Front stage: accepts input beats, checks indices and classifies the work.
module vna_front import vna_pkg::*; #(
    parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [CORNER_W-1:0] corner_a,
    input  logic [CORNER_W-1:0] corner_b,
    input  logic [CORNER_W-1:0] corner_c,
    input  logic [DATA_W-1:0]   pos_x,
    input  logic [DATA_W-1:0]   pos_y,
    input  logic [DATA_W-1:0]   pos_z,
    input  logic [DATA_W-1:0]   start_nx,
    input  logic [DATA_W-1:0]   start_ny,
    input  logic [DATA_W-1:0]   start_nz,
    input  logic                q_full,
    output logic                q_push,
    output item_t               q_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  in_a;
    logic  in_b;
    logic  in_c;
    logic  keep;
    logic  accept;

    assign in_a = (32'(corner_a) < 32'(VERTEX_SLOTS));
    assign in_b = (32'(corner_b) < 32'(VERTEX_SLOTS));
    assign in_c = (32'(corner_c) < 32'(VERTEX_SLOTS));

    // Unused commands and out-of-range loads or triangles leave no trace.
    always_comb
    begin
        keep = 1'b0;
        item_next.op = OP_LOAD;
        case (cmd)
            CMD_LOAD:
            begin
                keep = in_a;
                item_next.op = OP_LOAD;
            end
            CMD_TRI:
            begin
                keep = in_a && in_b && in_c;
                item_next.op = OP_TRI;
            end
            CMD_READ:
            begin
                keep = 1'b1;
                item_next.op = in_a ? OP_READ : OP_ZERO;
            end
            default:
            begin
                keep = 1'b0;
                item_next.op = OP_LOAD;
            end
        endcase
        item_next.ca  = corner_a;
        item_next.cb  = corner_b;
        item_next.cc  = corner_c;
        item_next.pos = {pos_z, pos_y, pos_x};
        item_next.nrm = {start_nz, start_ny, start_nx};
    end

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = valid_reg && !q_full;
    assign q_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg <= keep;
            end
            else if (q_push)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

FILE: hw/rtl/vna_queue.sv
// Short queue of classified work between the front and back stages.
module vna_queue import vna_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item_in,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t item_out
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign item_out = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= item_in;
        end
    end

endmodule

FILE: hw/rtl/vna_back.sv
// Back stage: vertex store, face normal arithmetic and normal accumulation.
module vna_back import vna_pkg::*; #(
    parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] normal_x,
    output logic [DATA_W-1:0] normal_y,
    output logic [DATA_W-1:0] normal_z
);

    localparam int AW = $clog2(VERTEX_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_RD, S_RDW, S_PA, S_PB, S_PC, S_EDGE, S_SCALE,
        S_MUL, S_ABS, S_NORM, S_SQ, S_SQRT, S_DIVI, S_DIV, S_NRD, S_NWR
    } state_t;

    state_t state_reg;
    item_t  item_reg;
    logic   out_valid_reg;
    logic [DATA_W-1:0] nx_reg;
    logic [DATA_W-1:0] ny_reg;
    logic [DATA_W-1:0] nz_reg;

    logic [2:0][DATA_W-1:0] pa_reg;
    logic [2:0][DATA_W-1:0] pb_reg;
    logic signed [32:0] ed_reg [6];
    logic signed [30:0] e_reg [6];
    logic signed [61:0] prod_reg;
    logic signed [62:0] cr_reg [3];
    logic        [2:0]  sgn_reg;
    logic        [61:0] u_reg [3];
    logic        [59:0] usq_reg;
    logic        [61:0] sum_reg;
    logic        [61:0] sx_reg;
    logic        [61:0] sr_reg;
    logic        [61:0] sbit_reg;
    logic        [30:0] len_reg;
    logic        [46:0] rem_reg;
    logic        [46:0] dvs_reg;
    logic        [16:0] q_reg;
    logic signed [17:0] n_reg [3];
    logic        [4:0]  cnt_reg;
    logic        [1:0]  k_reg;

    // Store ports.
    logic                   pos_we;
    logic                   pos_re;
    logic [AW-1:0]          pos_raddr;
    logic [2:0][DATA_W-1:0] pos_rd;
    logic                   nrm_we;
    logic                   nrm_re;
    logic [AW-1:0]          nrm_addr;
    logic [2:0][DATA_W-1:0] nrm_wdata;
    logic [2:0][DATA_W-1:0] nrm_rd;

    logic [CORNER_W-1:0] corner_sel;
    logic [32:0]         mag [6];
    logic [32:0]         mag_or;
    logic [1:0]          shamt;
    logic signed [30:0]  mul_a;
    logic signed [30:0]  mul_b;
    logic [61:0]         u_or;
    logic [61:0]         u_cur;
    logic [61:0]         sq_trial;
    logic                div_take;
    logic [16:0]         q_step;
    logic [2:0][DATA_W-1:0] sat;
    logic signed [32:0]  sat_sum [3];

    always_comb
    begin
        case (k_reg)
            2'd0:    corner_sel = item_reg.ca;
            2'd1:    corner_sel = item_reg.cb;
            default: corner_sel = item_reg.cc;
        endcase
        case (k_reg)
            2'd0:    u_cur = u_reg[0];
            2'd1:    u_cur = u_reg[1];
            default: u_cur = u_reg[2];
        endcase
    end

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign pos_we    = (state_reg == S_LOAD);
    assign pos_re    = (state_reg == S_PA) || (state_reg == S_PB) || (state_reg == S_PC);
    assign pos_raddr = (state_reg == S_PA) ? AW'(item_reg.ca) :
                       (state_reg == S_PB) ? AW'(item_reg.cb) : AW'(item_reg.cc);
    assign nrm_we    = (state_reg == S_LOAD) || (state_reg == S_NWR);
    assign nrm_re    = (state_reg == S_RD) || (state_reg == S_NRD);
    assign nrm_addr  = (state_reg == S_LOAD || state_reg == S_RD) ? AW'(item_reg.ca)
                                                                   : AW'(corner_sel);
    assign nrm_wdata = (state_reg == S_LOAD) ? item_reg.nrm : sat;

    vna_ram #(.WIDTH(3 * DATA_W), .DEPTH(VERTEX_SLOTS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (AW'(item_reg.ca)),
        .wdata (item_reg.pos),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rd)
    );

    // Write and read share one address: a corner is never read and written in one cycle.
    vna_ram #(.WIDTH(3 * DATA_W), .DEPTH(VERTEX_SLOTS)) u_nrm_ram (
        .clk   (clk),
        .we    (nrm_we),
        .waddr (nrm_addr),
        .wdata (nrm_wdata),
        .re    (nrm_re),
        .raddr (nrm_addr),
        .rdata (nrm_rd)
    );

    // Edge scaling: the top set bit of the ORed magnitudes gives the shift.
    always_comb
    begin
        mag_or = '0;
        for (int i = 0; i < 6; i++)
        begin
            mag[i] = ed_reg[i][32] ? 33'(-ed_reg[i]) : 33'(ed_reg[i]);
            mag_or = mag_or | mag[i];
        end
        shamt = mag_or[32] ? 2'd3 : mag_or[31] ? 2'd2 : mag_or[30] ? 2'd1 : 2'd0;
    end

    // Cross product operand pairs, two per component.
    always_comb
    begin
        case (cnt_reg)
            5'd0:    begin mul_a = e_reg[1]; mul_b = e_reg[5]; end
            5'd1:    begin mul_a = e_reg[2]; mul_b = e_reg[4]; end
            5'd2:    begin mul_a = e_reg[2]; mul_b = e_reg[3]; end
            5'd3:    begin mul_a = e_reg[0]; mul_b = e_reg[5]; end
            5'd4:    begin mul_a = e_reg[0]; mul_b = e_reg[4]; end
            default: begin mul_a = e_reg[1]; mul_b = e_reg[3]; end
        endcase
    end

    assign u_or     = u_reg[0] | u_reg[1] | u_reg[2];
    assign sq_trial = sr_reg + sbit_reg;
    assign div_take = (rem_reg >= dvs_reg);
    assign q_step   = {q_reg[15:0], div_take};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sat_sum[i] = 33'(signed'(nrm_rd[i])) + 33'(n_reg[i]);
            if (sat_sum[i][32] != sat_sum[i][31])
            begin
                sat[i] = sat_sum[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                sat[i] = sat_sum[i][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            nz_reg        <= '0;
        end
        else
        begin
            // A result beat that leaves is refilled by the read state itself.
            if (out_valid_reg && !out_stall && state_reg != S_RDW)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_item.op)
                            OP_LOAD: state_reg <= S_LOAD;
                            OP_TRI:  state_reg <= S_PA;
                            default: state_reg <= S_RD;
                        endcase
                    end
                end
                S_LOAD:  state_reg <= S_IDLE;
                S_RD:    state_reg <= S_RDW;
                S_RDW:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        nx_reg <= (item_reg.op == OP_ZERO) ? '0 : nrm_rd[0];
                        ny_reg <= (item_reg.op == OP_ZERO) ? '0 : nrm_rd[1];
                        nz_reg <= (item_reg.op == OP_ZERO) ? '0 : nrm_rd[2];
                        state_reg <= S_IDLE;
                    end
                end
                S_PA:    state_reg <= S_PB;
                S_PB:    state_reg <= S_PC;
                S_PC:    state_reg <= S_EDGE;
                S_EDGE:  state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_MUL;
                S_MUL:
                begin
                    if (cnt_reg == 5'd6)
                    begin
                        state_reg <= S_ABS;
                    end
                end
                S_ABS:
                begin
                    // A degenerate triangle adds nothing.
                    if (cr_reg[0] == '0 && cr_reg[1] == '0 && cr_reg[2] == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (u_or[61:30] == '0 && u_or[29])
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (cnt_reg == 5'd3)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sbit_reg == '0)
                    begin
                        state_reg <= S_DIVI;
                    end
                end
                S_DIVI:  state_reg <= S_DIV;
                S_DIV:
                begin
                    if (cnt_reg == 5'd16)
                    begin
                        state_reg <= (k_reg == 2'd2) ? S_NRD : S_DIVI;
                    end
                end
                S_NRD:   state_reg <= S_NWR;
                S_NWR:
                begin
                    state_reg <= (k_reg == 2'd2) ? S_IDLE : S_NRD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_reg <= q_item;
                end
                k_reg <= 2'd0;
            end
            S_PB: pa_reg <= pos_rd;
            S_PC: pb_reg <= pos_rd;
            S_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ed_reg[i]     <= 33'(signed'(pb_reg[i])) - 33'(signed'(pa_reg[i]));
                    ed_reg[i + 3] <= 33'(signed'(pos_rd[i])) - 33'(signed'(pa_reg[i]));
                end
            end
            S_SCALE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    e_reg[i] <= ed_reg[i][32] ? -31'(mag[i] >> shamt) : 31'(mag[i] >> shamt);
                end
                cnt_reg <= 5'd0;
            end
            S_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                cnt_reg  <= cnt_reg + 1'b1;
                // The product of the previous cycle goes into its component.
                case (cnt_reg)
                    5'd1:    cr_reg[0] <= 63'(prod_reg);
                    5'd2:    cr_reg[0] <= cr_reg[0] - 63'(prod_reg);
                    5'd3:    cr_reg[1] <= 63'(prod_reg);
                    5'd4:    cr_reg[1] <= cr_reg[1] - 63'(prod_reg);
                    5'd5:    cr_reg[2] <= 63'(prod_reg);
                    5'd6:    cr_reg[2] <= cr_reg[2] - 63'(prod_reg);
                    default: ;
                endcase
            end
            S_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sgn_reg[i] <= cr_reg[i][62];
                    u_reg[i]   <= cr_reg[i][62] ? 62'(-cr_reg[i]) : 62'(cr_reg[i]);
                end
            end
            S_NORM:
            begin
                if (u_or[61:30] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u_reg[i] <= u_reg[i] >> 1;
                    end
                end
                else if (!u_or[29])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        u_reg[i] <= u_reg[i] << 1;
                    end
                end
                cnt_reg <= 5'd0;
                sum_reg <= '0;
            end
            S_SQ:
            begin
                case (cnt_reg)
                    5'd0:    usq_reg <= u_reg[0][29:0] * u_reg[0][29:0];
                    5'd1:    usq_reg <= u_reg[1][29:0] * u_reg[1][29:0];
                    default: usq_reg <= u_reg[2][29:0] * u_reg[2][29:0];
                endcase
                if (cnt_reg != 5'd0)
                begin
                    sum_reg <= sum_reg + 62'(usq_reg);
                end
                cnt_reg  <= cnt_reg + 1'b1;
                sx_reg   <= sum_reg + 62'(usq_reg);
                sr_reg   <= '0;
                sbit_reg <= 62'(1) << 60;
            end
            S_SQRT:
            begin
                if (sbit_reg != '0)
                begin
                    if (sx_reg >= sq_trial)
                    begin
                        sx_reg <= sx_reg - sq_trial;
                        sr_reg <= (sr_reg >> 1) + sbit_reg;
                    end
                    else
                    begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                end
                len_reg <= sr_reg[30:0];
            end
            S_DIVI:
            begin
                rem_reg <= (47'(u_cur[29:0]) << 16) + 47'(len_reg >> 1);
                dvs_reg <= 47'(len_reg) << 16;
                q_reg   <= '0;
                cnt_reg <= 5'd0;
            end
            S_DIV:
            begin
                if (div_take)
                begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
                q_reg   <= q_step;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd16)
                begin
                    case (k_reg)
                        2'd0:    n_reg[0] <= sgn_reg[0] ? -18'(q_step) : 18'(q_step);
                        2'd1:    n_reg[1] <= sgn_reg[1] ? -18'(q_step) : 18'(q_step);
                        default: n_reg[2] <= sgn_reg[2] ? -18'(q_step) : 18'(q_step);
                    endcase
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end
            end
            S_NWR:
            begin
                k_reg <= k_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign normal_z  = nz_reg;

endmodule

FILE: hw/rtl/vertex_normal_accumulator_top.sv
// Top level of the vertex normal accumulator.
// Beats enter through a classifying front stage and a two-entry queue and reach the back
// stage through the front register and the queue; the back stage works on one beat at a time.
// A read waits in the back stage while a stalled result holds the output register. For a
// triangle the bit-serial square root and three bit-serial divisions dominate, with a
// normalising shift of one bit per cycle and a read-modify-write of each corner's normal
// in turn; a degenerate triangle stops before normalising. The vertex store is not
// cleared at reset; a vertex must be loaded before it is used.
module vertex_normal_accumulator_top import vna_pkg::*; #(
    parameter int VERTEX_SLOTS = VERTEX_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [CORNER_W-1:0] corner_a,
    input  logic [CORNER_W-1:0] corner_b,
    input  logic [CORNER_W-1:0] corner_c,
    input  logic [DATA_W-1:0]   pos_x,
    input  logic [DATA_W-1:0]   pos_y,
    input  logic [DATA_W-1:0]   pos_z,
    input  logic [DATA_W-1:0]   start_nx,
    input  logic [DATA_W-1:0]   start_ny,
    input  logic [DATA_W-1:0]   start_nz,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   normal_x,
    output logic [DATA_W-1:0]   normal_y,
    output logic [DATA_W-1:0]   normal_z
);

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    item_t f_item;
    item_t q_item;

    vna_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .corner_a (corner_a),
        .corner_b (corner_b),
        .corner_c (corner_c),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .start_nx (start_nx),
        .start_ny (start_ny),
        .start_nz (start_nz),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (f_item)
    );

    vna_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (f_item),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .item_out (q_item)
    );

    vna_back #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .normal_x  (normal_x),
        .normal_y  (normal_y),
        .normal_z  (normal_z)
    );

endmodule

FILE: hw/rtl/vna_checker.sv
// Port-level checks for the vertex normal accumulator, bound to the top level.
module vna_checker import vna_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic [1:0]          cmd,
    input logic                out_valid,
    input logic                out_stall,
    input logic [DATA_W-1:0]   normal_x,
    input logic [DATA_W-1:0]   normal_y,
    input logic [DATA_W-1:0]   normal_z
);

    localparam int PEND_MAX = QUEUE_DEPTH + 3;

    logic [3:0] pend_reg;
    logic       rd_beat;
    logic       out_beat;

    assign rd_beat  = in_valid && !in_stall && (cmd == CMD_READ);
    assign out_beat = out_valid && !out_stall;

    // Reads taken in but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 4'(rd_beat) - 4'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(normal_x)
                                   && $stable(normal_y) && $stable(normal_z))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> pend_reg != 4'd0)
        else $error("result without a read");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'(PEND_MAX))
        else $error("too many reads outstanding");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (.*);
